FILE: design/dxt_pkg.sv
// Shared types and constants for the DXT3/DXT5 block decoder.
// Used by every module of the block; depends on nothing.
package dxt_pkg;

  // 2^15 / d, rounded up; exact over the numerator ranges used here
  localparam int unsigned RecipShift = 15;
  localparam logic [13:0] RECIP_DIV3 = 14'd10923;
  localparam logic [13:0] RECIP_DIV5 = 14'd6554;
  localparam logic [13:0] RECIP_DIV7 = 14'd4682;
  localparam logic [3:0]  LAST_PIXEL_INDEX = 4'd15;

  typedef struct packed {
    logic [63:0] alpha_word;
    logic [63:0] color_word;
  } dxt_blk_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] pixel_alpha;
    logic [3:0] pixel_index;
    logic       last_pixel;
  } dxt_pix_t;

  // stage 1: one pixel's indices with the block endpoints expanded
  typedef struct packed {
    logic [3:0] pixel_index;
    logic       last_pixel;
    logic [1:0] color_sel;
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [2:0] alpha_sel;
    logic [3:0] alpha_nibble;
  } dxt_s1_t;

  // stage 2: numerators ready for division, or a bypass value in the low bits
  typedef struct packed {
    logic [3:0]  pixel_index;
    logic        last_pixel;
    logic        color_bypass;
    logic [9:0]  red_num;
    logic [9:0]  green_num;
    logic [9:0]  blue_num;
    logic        alpha_bypass;
    logic        alpha_div7;
    logic [10:0] alpha_num;
  } dxt_s2_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] count;
  } dxt_issue_stat_t;

endpackage

FILE: design/dxt_issue.sv
// Block buffer and pixel sequencer: holds one block, issues one pixel per cycle
// on move. Registers stage 1 (indices, expanded endpoints). Depends on dxt_pkg.
module dxt_issue import dxt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            blk_valid,
  input  dxt_blk_t        blk,
  output logic            blk_stall,
  input  logic            move,
  output logic            s1_valid,
  output dxt_s1_t         s1,
  output dxt_issue_stat_t stat
);

  logic       buf_valid;
  logic [3:0] cnt;
  dxt_blk_t   blk_buf;
  logic       issue;
  logic       done;
  logic       accept;
  dxt_s1_t    s1_next;
  logic [5:0] color_base;
  logic [5:0] alpha_base;
  logic [4:0] r5_0, b5_0, r5_1, b5_1;
  logic [5:0] g6_0, g6_1;

  assign issue     = buf_valid && move;
  assign done      = issue && (cnt == LAST_PIXEL_INDEX);
  assign blk_stall = buf_valid && !done;
  assign accept    = blk_valid && !blk_stall;
  assign stat      = '{busy: buf_valid, count: cnt};

  assign color_base = {1'b1, cnt, 1'b0};
  assign alpha_base = 6'd16 + {2'b00, cnt} + {1'b0, cnt, 1'b0};

  assign r5_0 = blk_buf.color_word[15:11];
  assign g6_0 = blk_buf.color_word[10:5];
  assign b5_0 = blk_buf.color_word[4:0];
  assign r5_1 = blk_buf.color_word[31:27];
  assign g6_1 = blk_buf.color_word[26:21];
  assign b5_1 = blk_buf.color_word[20:16];

  always_comb begin
    s1_next.pixel_index  = cnt;
    s1_next.last_pixel   = (cnt == LAST_PIXEL_INDEX);
    s1_next.color_sel    = blk_buf.color_word[color_base +: 2];
    s1_next.r0           = {r5_0, r5_0[4:2]};
    s1_next.g0           = {g6_0, g6_0[5:4]};
    s1_next.b0           = {b5_0, b5_0[4:2]};
    s1_next.r1           = {r5_1, r5_1[4:2]};
    s1_next.g1           = {g6_1, g6_1[5:4]};
    s1_next.b1           = {b5_1, b5_1[4:2]};
    s1_next.a0           = blk_buf.alpha_word[7:0];
    s1_next.a1           = blk_buf.alpha_word[15:8];
    s1_next.alpha_sel    = blk_buf.alpha_word[alpha_base +: 3];
    s1_next.alpha_nibble = blk_buf.alpha_word[{cnt, 2'b00} +: 4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      cnt       <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        buf_valid <= 1'b1;
        cnt       <= '0;
      end else if (done) begin
        buf_valid <= 1'b0;
        cnt       <= '0;
      end else if (issue) begin
        cnt <= cnt + 4'd1;
      end
      if (move) begin
        s1_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_buf <= blk;
    end
    if (issue) begin
      s1 <= s1_next;
    end
  end

endmodule

FILE: design/dxt_weight.sv
// Stage 2: forms weighted endpoint sums for colour and alpha interpolation,
// or a bypass value (endpoint, DXT3 alpha, 0 or 255). Depends on dxt_pkg.
module dxt_weight import dxt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    move,
  input  logic    alpha_mode,
  input  logic    s1_valid,
  input  dxt_s1_t s1,
  output logic    s2_valid,
  output dxt_s2_t s2
);

  dxt_s2_t     s2_next;
  logic [2:0]  w0;
  logic [2:0]  w1;
  logic [10:0] bias;

  // selector 2 weighs e0 double, selector 3 weighs e1 double
  function automatic logic [9:0] color_num(input logic [1:0] sel,
                                           input logic [7:0] e0,
                                           input logic [7:0] e1);
    logic [9:0] v;
    unique case (sel)
      2'd0:    v = {2'b00, e0};
      2'd1:    v = {2'b00, e1};
      2'd2:    v = {1'b0, e0, 1'b0} + {2'b00, e1} + 10'd1;
      default: v = {2'b00, e0} + {1'b0, e1, 1'b0} + 10'd1;
    endcase
    return v;
  endfunction

  always_comb begin
    s2_next.pixel_index  = s1.pixel_index;
    s2_next.last_pixel   = s1.last_pixel;
    s2_next.color_bypass = !s1.color_sel[1];
    s2_next.red_num      = color_num(s1.color_sel, s1.r0, s1.r1);
    s2_next.green_num    = color_num(s1.color_sel, s1.g0, s1.g1);
    s2_next.blue_num     = color_num(s1.color_sel, s1.b0, s1.b1);

    s2_next.alpha_div7 = (s1.a0 > s1.a1);
    w1   = s1.alpha_sel - 3'd1;
    if (s2_next.alpha_div7) begin
      w0   = 3'd0 - s1.alpha_sel;
      bias = 11'd3;
    end else begin
      w0   = 3'd6 - s1.alpha_sel;
      bias = 11'd2;
    end

    priority if (!alpha_mode) begin
      s2_next.alpha_bypass = 1'b1;
      s2_next.alpha_num    = {3'b000, s1.alpha_nibble, s1.alpha_nibble};
    end else if (s1.alpha_sel == 3'd0) begin
      s2_next.alpha_bypass = 1'b1;
      s2_next.alpha_num    = {3'b000, s1.a0};
    end else if (s1.alpha_sel == 3'd1) begin
      s2_next.alpha_bypass = 1'b1;
      s2_next.alpha_num    = {3'b000, s1.a1};
    end else if (!s2_next.alpha_div7 && s1.alpha_sel == 3'd6) begin
      s2_next.alpha_bypass = 1'b1;
      s2_next.alpha_num    = 11'd0;
    end else if (!s2_next.alpha_div7 && s1.alpha_sel == 3'd7) begin
      s2_next.alpha_bypass = 1'b1;
      s2_next.alpha_num    = 11'd255;
    end else begin
      s2_next.alpha_bypass = 1'b0;
      s2_next.alpha_num    = ({8'd0, w0} * {3'b000, s1.a0})
                           + ({8'd0, w1} * {3'b000, s1.a1}) + bias;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (move) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s1_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

FILE: design/dxt_divide.sv
// Stage 3: divides the sums by 3, 5 or 7 through reciprocal multiplication
// and registers the finished pixel on the output port. Depends on dxt_pkg.
module dxt_divide import dxt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     move,
  input  logic     s2_valid,
  input  dxt_s2_t  s2,
  output logic     pix_valid,
  output dxt_pix_t pix
);

  logic [23:0] prod_r, prod_g, prod_b;
  logic [24:0] prod_a;
  logic [13:0] alpha_recip;
  dxt_pix_t    pix_next;

  assign alpha_recip = s2.alpha_div7 ? RECIP_DIV7 : RECIP_DIV5;
  assign prod_r = {14'd0, s2.red_num}   * {10'd0, RECIP_DIV3};
  assign prod_g = {14'd0, s2.green_num} * {10'd0, RECIP_DIV3};
  assign prod_b = {14'd0, s2.blue_num}  * {10'd0, RECIP_DIV3};
  assign prod_a = {14'd0, s2.alpha_num} * {11'd0, alpha_recip};

  always_comb begin
    pix_next.pixel_index = s2.pixel_index;
    pix_next.last_pixel  = s2.last_pixel;
    if (s2.color_bypass) begin
      pix_next.red   = s2.red_num[7:0];
      pix_next.green = s2.green_num[7:0];
      pix_next.blue  = s2.blue_num[7:0];
    end else begin
      pix_next.red   = prod_r[RecipShift +: 8];
      pix_next.green = prod_g[RecipShift +: 8];
      pix_next.blue  = prod_b[RecipShift +: 8];
    end
    if (s2.alpha_bypass) begin
      pix_next.pixel_alpha = s2.alpha_num[7:0];
    end else begin
      pix_next.pixel_alpha = prod_a[RecipShift +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (move) begin
      pix_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s2_valid) begin
      pix <= pix_next;
    end
  end

endmodule

FILE: design/dxt_block_decoder.sv
// Top level of the DXT3/DXT5 block decoder: block buffer, three pipeline stages
// and the alpha mode register. Depends on dxt_pkg, dxt_issue, dxt_weight, dxt_divide.
//
//   channel  signals                          direction  request
//   blk      blk_valid, blk_stall, blk        in         one 16-byte block
//   pix      pix_valid, pix_stall, pix        out        one decoded pixel
//   cfg      cfg_write_en, cfg_write_data     in         alpha mode (1 = DXT5)
//
// Each block yields 16 pixels, one per cycle while pix_stall does not hold the pipeline;
// the pixel sequencer reads the one block buffer, so blocks are taken one at a time.
// The next block is accepted in the cycle its predecessor's last pixel issues.
// The first pixel passes through the block buffer, stage 1, stage 2 and the output register.
// pix_stall with a pixel waiting freezes the whole pipeline and the sequencer.
// Synchronous reset empties the pipeline and sets alpha mode to DXT5.
module dxt_block_decoder import dxt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     blk_valid,
  input  dxt_blk_t blk,
  output logic     blk_stall,
  output logic     pix_valid,
  output dxt_pix_t pix,
  input  logic     pix_stall,
  input  logic     cfg_write_en,
  input  logic     cfg_write_data
);

  logic            alpha_mode;
  logic            move;
  logic            s1_valid;
  dxt_s1_t         s1;
  logic            s2_valid;
  dxt_s2_t         s2;
  dxt_issue_stat_t stat;

  // hold every stage while a finished pixel waits
  assign move = !(pix_valid && pix_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b1;
    end else if (cfg_write_en) begin
      alpha_mode <= cfg_write_data;
    end
  end

  dxt_issue u_issue (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk       (blk),
    .blk_stall (blk_stall),
    .move      (move),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .stat      (stat)
  );

  dxt_weight u_weight (
    .clk        (clk),
    .rst        (rst),
    .move       (move),
    .alpha_mode (alpha_mode),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s2_valid   (s2_valid),
    .s2         (s2)
  );

  dxt_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .move      (move),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  a_accept_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (blk_valid && !blk_stall && stat.busy) |->
      (stat.count == LAST_PIXEL_INDEX && move))
    else $error("block accepted while buffer still issuing");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (blk_valid && !blk_stall) |=> (stat.busy && stat.count == 4'd0))
    else $error("accepted block not loaded at pixel zero");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |=> ($stable(s2_valid) && $stable(s1_valid)))
    else $error("pipeline advanced under output stall");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> (pix.last_pixel == (pix.pixel_index == LAST_PIXEL_INDEX)))
    else $error("last pixel flag disagrees with index");

endmodule
